// ===== design/seqpq_pkg.sv =====
`timescale 1ns / 1ps

package seqpq_pkg;

   // Default sizes of the queue store.
   localparam int DEF_NUM_PLAYERS = 5;
   localparam int DEF_QUEUE_DEPTH = 5;

   // Request operation codes.
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_REMOVE  = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   // Reported actions.
   localparam logic [1:0] ACT_NONE       = 2'd0;
   localparam logic [1:0] ACT_START      = 2'd1;
   localparam logic [1:0] ACT_STOP_START = 2'd2;
   localparam logic [1:0] ACT_STOP       = 2'd3;

   // One stored queue entry.
   typedef struct packed {
      logic [7:0] id;
      logic [7:0] priority_level;
   } entry_type;

   // One result as it leaves the block.
   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  head_id;
      logic [7:0]  head_priority;
      logic [10:0] fade_out;
      logic [2:0]  queue_length;
   } result_type;

   function automatic result_type make_result(
      input logic [1:0]  action,
      input logic [7:0]  head_id,
      input logic [7:0]  head_priority,
      input logic [10:0] fade_out,
      input logic [2:0]  queue_length
   );
      result_type r;
      r.action        = action;
      r.head_id       = head_id;
      r.head_priority = head_priority;
      r.fade_out      = fade_out;
      r.queue_length  = queue_length;
      return r;
   endfunction

endpackage

// ===== design/sequence_request_priority_queue_unit.sv =====
`timescale 1ns / 1ps

// Per-player sorted request queues. Each request carries an operation (enqueue,
// remove by id, clear), a player index and an (id, priority) pair; exactly one
// result comes back for every request, reporting whether the head must be
// started, stopped and restarted, or stopped, with the queue length afterwards.
// All entries sit in one memory with a write port and a registered read port,
// and a small sequencer walks the addressed queue through it, reading each
// examined entry and reading and writing each entry shifted on insert or
// removal; a clear or an out-of-range player needs no memory access. The block
// takes no new request until the current one has handed its result to the
// output register, which then waits for the consumer on its own.
module sequence_request_priority_queue_unit #(
   parameter int NUM_PLAYERS = seqpq_pkg::DEF_NUM_PLAYERS,
   parameter int QUEUE_DEPTH = seqpq_pkg::DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_player,
   input  logic [7:0]  req_id,
   input  logic [7:0]  req_priority,
   input  logic [7:0]  req_fade_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [7:0]  rsp_head_id,
   output logic [7:0]  rsp_head_priority,
   output logic [10:0] rsp_fade_out,
   output logic [2:0]  rsp_queue_length
);
   import seqpq_pkg::*;

   localparam int ENTRIES = NUM_PLAYERS * QUEUE_DEPTH;
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IW = $clog2(QUEUE_DEPTH + 1);
   localparam int PW = (NUM_PLAYERS > 1) ? $clog2(NUM_PLAYERS) : 1;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SCAN_RD  = 4'd1;
   localparam logic [3:0] ST_SCAN_CHK = 4'd2;
   localparam logic [3:0] ST_DECIDE   = 4'd3;
   localparam logic [3:0] ST_SH_RD    = 4'd4;
   localparam logic [3:0] ST_SH_WR    = 4'd5;
   localparam logic [3:0] ST_WR_NEW   = 4'd6;
   localparam logic [3:0] ST_FIN      = 4'd7;
   localparam logic [3:0] ST_HEAD_RD  = 4'd8;
   localparam logic [3:0] ST_DONE     = 4'd9;

   localparam logic [IW-1:0] DEPTH_CODE = IW'(QUEUE_DEPTH);

   logic [3:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [PW-1:0] player_ff, player_in;
   logic [7:0]    id_ff, id_in;
   logic [7:0]    pri_ff, pri_in;
   logic [10:0]   fade_ff, fade_in;
   logic [AW-1:0] base_ff, base_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic          pos_hit_ff, pos_hit_in;
   logic          match_ff, match_in;
   result_type    res_ff, res_in;
   result_type    rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0] count_ff [NUM_PLAYERS];
   logic          cnt_wr_en;
   logic [PW-1:0] cnt_wr_player;
   logic [IW-1:0] cnt_wr_val;

   entry_type     mem [ENTRIES];
   entry_type     rd_data_ff;
   logic          rd_en;
   logic [IW-1:0] rd_idx;
   logic          wr_en;
   logic [IW-1:0] wr_idx;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   logic          in_range;
   logic [PW-1:0] req_player_idx;
   logic [IW-1:0] req_cnt;
   logic [IW:0]   idx_next_wide;
   logic [IW-1:0] cnt_dec;

   assign in_range       = int'(req_player) < NUM_PLAYERS;
   assign req_player_idx = in_range ? PW'(req_player) : '0;
   assign req_cnt        = in_range ? count_ff[req_player_idx] : '0;
   assign idx_next_wide  = {1'b0, idx_ff} + 1'b1;
   assign cnt_dec        = cnt_ff - 1'b1;
   assign rd_addr        = base_ff + AW'(rd_idx);
   assign wr_addr        = base_ff + AW'(wr_idx);

   // Sequencer: scan the queue and shift entries as the operation needs, then form the result.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      player_in     = player_ff;
      id_in         = id_ff;
      pri_in        = pri_ff;
      fade_in       = fade_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      pos_hit_in    = pos_hit_ff;
      match_in      = match_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rd_en         = 1'b0;
      rd_idx        = '0;
      wr_en         = 1'b0;
      wr_idx        = '0;
      wr_data       = rd_data_ff;
      cnt_wr_en     = 1'b0;
      cnt_wr_player = player_ff;
      cnt_wr_val    = cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               player_in  = req_player_idx;
               id_in      = req_id;
               pri_in     = req_priority;
               fade_in    = {req_fade_time, 3'b000};
               base_in    = AW'(int'(req_player) * QUEUE_DEPTH);
               idx_in     = '0;
               pos_hit_in = 1'b0;
               match_in   = 1'b0;
               cnt_in     = req_cnt;
               pos_in     = req_cnt;
               if (!in_range) begin
                  res_in   = make_result(ACT_NONE, 8'd0, 8'd0, 11'd0, 3'd0);
                  state_in = ST_DONE;
               end else begin
                  case (req_op) inside
                     OP_ENQUEUE, OP_REMOVE: begin
                        state_in = ST_SCAN_RD;
                     end
                     OP_CLEAR: begin
                        cnt_wr_en     = 1'b1;
                        cnt_wr_player = req_player_idx;
                        cnt_wr_val    = '0;
                        res_in   = make_result(ACT_NONE, 8'd0, 8'd0, 11'd0, 3'd0);
                        state_in = ST_DONE;
                     end
                     default: begin
                        res_in   = make_result(ACT_NONE, 8'd0, 8'd0, 11'd0, 3'(req_cnt));
                        state_in = ST_DONE;
                     end
                  endcase
               end
            end
         end

         // Issue the read of the next entry, or finish the scan.
         ST_SCAN_RD: begin
            if (idx_ff == cnt_ff) begin
               state_in = ST_DECIDE;
            end else begin
               rd_en    = 1'b1;
               rd_idx   = idx_ff;
               state_in = ST_SCAN_CHK;
            end
         end

         // Compare the entry just read against the request.
         ST_SCAN_CHK: begin
            if (rd_data_ff.id == id_ff) begin
               if (op_ff == OP_ENQUEUE) begin
                  if (idx_ff == '0) begin
                     res_in = make_result(ACT_START, id_ff, pri_ff, fade_ff, 3'(cnt_ff));
                  end else begin
                     res_in = make_result(ACT_NONE, 8'd0, 8'd0, 11'd0, 3'(cnt_ff));
                  end
                  state_in = ST_DONE;
               end else begin
                  pos_in   = idx_ff;
                  match_in = 1'b1;
                  state_in = ST_DECIDE;
               end
            end else begin
               if (!pos_hit_ff && (rd_data_ff.priority_level <= pri_ff)) begin
                  pos_in     = idx_ff;
                  pos_hit_in = 1'b1;
               end
               idx_in   = idx_next_wide[IW-1:0];
               state_in = ST_SCAN_RD;
            end
         end

         ST_DECIDE: begin
            if (op_ff == OP_ENQUEUE) begin
               if (pos_ff == DEPTH_CODE) begin
                  res_in   = make_result(ACT_NONE, 8'd0, 8'd0, 11'd0, 3'(cnt_ff));
                  state_in = ST_DONE;
               end else begin
                  if (cnt_ff != DEPTH_CODE) begin
                     cnt_in = cnt_ff + 1'b1;
                     idx_in = cnt_ff;
                  end else begin
                     idx_in = cnt_dec;
                  end
                  state_in = ST_SH_RD;
               end
            end else if (match_ff) begin
               idx_in   = pos_ff;
               state_in = ST_SH_RD;
            end else begin
               if (cnt_ff == '0) begin
                  res_in = make_result(ACT_STOP, 8'd0, 8'd0, fade_ff, 3'd0);
               end else begin
                  res_in = make_result(ACT_NONE, 8'd0, 8'd0, 11'd0, 3'(cnt_ff));
               end
               state_in = ST_DONE;
            end
         end

         // Shift towards the tail on insert, towards the head on removal.
         ST_SH_RD: begin
            if (op_ff == OP_ENQUEUE) begin
               if (idx_ff == pos_ff) begin
                  state_in = ST_WR_NEW;
               end else begin
                  rd_en    = 1'b1;
                  rd_idx   = idx_ff - 1'b1;
                  state_in = ST_SH_WR;
               end
            end else begin
               if (idx_next_wide >= {1'b0, cnt_ff}) begin
                  state_in = ST_FIN;
               end else begin
                  rd_en    = 1'b1;
                  rd_idx   = idx_next_wide[IW-1:0];
                  state_in = ST_SH_WR;
               end
            end
         end

         ST_SH_WR: begin
            wr_en  = 1'b1;
            wr_idx = idx_ff;
            if (op_ff == OP_ENQUEUE) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               idx_in = idx_next_wide[IW-1:0];
            end
            state_in = ST_SH_RD;
         end

         ST_WR_NEW: begin
            wr_en                  = 1'b1;
            wr_idx                 = pos_ff;
            wr_data.id             = id_ff;
            wr_data.priority_level = pri_ff;
            cnt_wr_en              = 1'b1;
            cnt_wr_val             = cnt_ff;
            if (pos_ff == '0) begin
               res_in = make_result(ACT_START, id_ff, pri_ff, fade_ff, 3'(cnt_ff));
            end else begin
               res_in = make_result(ACT_NONE, 8'd0, 8'd0, 11'd0, 3'(cnt_ff));
            end
            state_in = ST_DONE;
         end

         // Removal done: store the new count and report on the head.
         ST_FIN: begin
            cnt_wr_en  = 1'b1;
            cnt_wr_val = cnt_dec;
            cnt_in     = cnt_dec;
            if ((pos_ff == '0) && (cnt_dec != '0)) begin
               rd_en    = 1'b1;
               rd_idx   = '0;
               state_in = ST_HEAD_RD;
            end else begin
               if (pos_ff == '0) begin
                  res_in = make_result(ACT_STOP, 8'd0, 8'd0, fade_ff, 3'(cnt_dec));
               end else begin
                  res_in = make_result(ACT_NONE, 8'd0, 8'd0, 11'd0, 3'(cnt_dec));
               end
               state_in = ST_DONE;
            end
         end

         ST_HEAD_RD: begin
            res_in = make_result(ACT_STOP_START, rd_data_ff.id, rd_data_ff.priority_level,
                                 fade_ff, 3'(cnt_ff));
            state_in = ST_DONE;
         end

         // Hand the result over once the output register is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers and queue counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NUM_PLAYERS; p++) begin
            count_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_wr_en) begin
            count_ff[cnt_wr_player] <= cnt_wr_val;
         end
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      player_ff  <= player_in;
      id_ff      <= id_in;
      pri_ff     <= pri_in;
      fade_ff    <= fade_in;
      base_ff    <= base_in;
      cnt_ff     <= cnt_in;
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      pos_hit_ff <= pos_hit_in;
      match_ff   <= match_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // Entry memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_ff.action;
   assign rsp_head_id       = rsp_ff.head_id;
   assign rsp_head_priority = rsp_ff.head_priority;
   assign rsp_fade_out      = rsp_ff.fade_out;
   assign rsp_queue_length  = rsp_ff.queue_length;

   // A request taken in makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted but block still ready");

   // A new result only appears after the sequencer has finished.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the hand-over state");

   // Memory writes stay inside the addressed player's rows.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (int'(wr_idx) < QUEUE_DEPTH))
      else $error("entry write beyond the queue depth");

   // A queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff <= DEPTH_CODE))
      else $error("queue count exceeds depth");

   // No action means no fade is reported.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_NONE)) |-> (rsp_fade_out == 11'd0))
      else $error("fade reported without an action");

endmodule
